// ===== rtl/prpi_pkg.sv =====
// Shared types, widths and codes of the PageRank power iteration core.
package prpi_pkg;

   // Default sizes
   localparam int DEF_MAX_VERTICES = 1024;
   localparam int DEF_MAX_EDGES    = 8192;

   // Field widths
   localparam int CMD_W       = 2;
   localparam int VTX_W       = 10;
   localparam int STATUS_W    = 2;
   localparam int RANK_W      = 32;
   localparam int ITER_W      = 16;
   localparam int RES_W       = 34;
   localparam int DAMP_W      = 16;
   localparam int VCOUNT_W    = 11;
   localparam int CSR_DATA_W  = 34;
   localparam int CSR_INDEX_W = 2;

   // Command codes
   localparam logic [CMD_W-1:0] CMD_ADD_EDGE = 2'd0;
   localparam logic [CMD_W-1:0] CMD_RUN      = 2'd1;
   localparam logic [CMD_W-1:0] CMD_READ     = 2'd2;
   localparam logic [CMD_W-1:0] CMD_CLEAR    = 2'd3;

   // Status codes
   localparam logic [STATUS_W-1:0] STATUS_OK    = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_RANGE = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_FULL  = 2'd2;

   // Register indexes
   localparam logic [CSR_INDEX_W-1:0] REG_VERTEX_COUNT    = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] REG_DAMPING         = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] REG_TOLERANCE       = 2'd2;
   localparam logic [CSR_INDEX_W-1:0] REG_ITERATION_LIMIT = 2'd3;

   // Register reset values
   localparam logic [VCOUNT_W-1:0] RST_VERTEX_COUNT    = 11'd1;
   localparam logic [DAMP_W-1:0]   RST_DAMPING         = 16'd55706;
   localparam logic [RES_W-1:0]    RST_TOLERANCE       = 34'd2147;
   localparam logic [ITER_W-1:0]   RST_ITERATION_LIMIT = 16'd100;

   // Saturation limits
   localparam logic [RANK_W-1:0] RANK_MAX     = 32'hFFFF_FFFF;
   localparam logic [RES_W-1:0]  RESIDUAL_MAX = 34'h3_FFFF_FFFF;

   typedef struct packed {
      logic [CMD_W-1:0] command;
      logic [VTX_W-1:0] edge_source;
      logic [VTX_W-1:0] edge_target;
      logic [VTX_W-1:0] query_vertex;
   } req_type;

   typedef struct packed {
      logic [STATUS_W-1:0] status;
      logic [RANK_W-1:0]   rank_value;
      logic [ITER_W-1:0]   iterations_done;
      logic                converged;
      logic [RES_W-1:0]    residual;
   } rsp_type;

endpackage

// ===== rtl/prpi_divider.sv =====
// Restoring unsigned divider, one quotient bit per cycle.
module prpi_divider import prpi_pkg::*; #(
   parameter int DVDW = 42,
   parameter int DVSW = 14
) (
   input  logic            clock,
   input  logic            reset,
   input  logic            start,
   input  logic [DVDW-1:0] dividend,
   input  logic [DVSW-1:0] divisor,
   output logic            busy,
   output logic            done,
   output logic [DVDW-1:0] quotient
);

   localparam int CW = $clog2(DVDW + 1);

   logic [DVDW-1:0] quo_ff;
   logic [DVSW-1:0] rem_ff;
   logic [DVSW-1:0] dsr_ff;
   logic [CW-1:0]   cnt_ff;
   logic            busy_ff;
   logic            done_ff;

   logic [DVSW:0] trial;
   logic [DVSW:0] diff;
   logic          fits;

   // Shift in the next dividend bit and try to subtract
   assign trial = {rem_ff, quo_ff[DVDW-1]};
   assign fits  = trial >= {1'b0, dsr_ff};
   assign diff  = trial - {1'b0, dsr_ff};

   // Control
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff <= 1'b1;
            cnt_ff  <= CW'(DVDW);
         end else if (busy_ff) begin
            cnt_ff <= cnt_ff - CW'(1);
            if (cnt_ff == CW'(1)) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   // Datapath
   always_ff @(posedge clock) begin
      if (start) begin
         quo_ff <= dividend;
         rem_ff <= '0;
         dsr_ff <= divisor;
      end else if (busy_ff) begin
         quo_ff <= {quo_ff[DVDW-2:0], fits};
         rem_ff <= fits ? diff[DVSW-1:0] : trial[DVSW-1:0];
      end
   end

   assign busy     = busy_ff;
   assign done     = done_ff;
   assign quotient = quo_ff;

endmodule

// ===== rtl/prpi_multiplier.sv =====
// Shift-add multiplier by the damping factor, returns floor(x * d / 2^16).
module prpi_multiplier import prpi_pkg::*; #(
   parameter int XW = 46
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   input  logic [XW-1:0]     x,
   input  logic [DAMP_W-1:0] d,
   output logic              done,
   output logic [XW-1:0]     product
);

   localparam int PW = XW + DAMP_W;
   localparam int CW = $clog2(DAMP_W + 1);

   logic [PW-1:0]     acc_ff;
   logic [PW-1:0]     xs_ff;
   logic [DAMP_W-1:0] ds_ff;
   logic [CW-1:0]     cnt_ff;
   logic              busy_ff;
   logic              done_ff;

   // Control
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff <= 1'b1;
            cnt_ff  <= CW'(DAMP_W);
         end else if (busy_ff) begin
            cnt_ff <= cnt_ff - CW'(1);
            if (cnt_ff == CW'(1)) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   // Add the shifted operand for each set bit of the damping factor
   always_ff @(posedge clock) begin
      if (start) begin
         acc_ff <= '0;
         xs_ff  <= PW'(x);
         ds_ff  <= d;
      end else if (busy_ff) begin
         if (ds_ff[0]) begin
            acc_ff <= acc_ff + xs_ff;
         end
         xs_ff <= {xs_ff[PW-2:0], 1'b0};
         ds_ff <= {1'b0, ds_ff[DAMP_W-1:1]};
      end
   end

   assign done    = done_ff;
   assign product = acc_ff[PW-1:DAMP_W];

endmodule

// ===== rtl/pagerank_power_iteration_core.sv =====
// PageRank power iteration core with dangling-node redistribution, in fixed point.
// Every item gives one result. After reset the core sweeps its degree and rank memories
// once and takes no item meanwhile. An edge load passes through a degree update, a rank
// read through a read wait, and a clear sweeps the degree memory. A run uses the shared
// divider and the shift-add multiplier: two divisions for setup and a rank fill, then per
// iteration a mass pass over the vertices, one multiplication and one division for the
// share, one division per usable edge and one multiplication per vertex.
module pagerank_power_iteration_core import prpi_pkg::*; #(
   parameter int MAX_VERTICES = DEF_MAX_VERTICES,
   parameter int MAX_EDGES    = DEF_MAX_EDGES
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_stall,
   input  req_type                req_item,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output rsp_type                rsp_item,
   input  logic                   csr_write,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_data
);

   // Derived sizes
   localparam int VW    = $clog2(MAX_VERTICES);
   localparam int NW    = $clog2(MAX_VERTICES + 1);
   localparam int ECW   = $clog2(MAX_EDGES + 1);
   localparam int EAW   = (MAX_EDGES > 1) ? $clog2(MAX_EDGES) : 1;
   localparam int DGW   = ECW;
   localparam int DVSW  = (DGW > NW) ? DGW : NW;
   localparam int MASSW = RANK_W + VW;
   localparam int DVDW  = MASSW;
   localparam int SUMW  = RANK_W + ECW;
   localparam int MULW  = (SUMW > MASSW) ? SUMW : MASSW;
   localparam int NXW   = MULW + 2;
   localparam int CMPW  = (NW > VCOUNT_W) ? NW : VCOUNT_W;
   localparam int EDW   = 2 * VTX_W;

   // Sequencer states
   localparam logic [4:0] S_SWEEP     = 5'd0;
   localparam logic [4:0] S_IDLE      = 5'd1;
   localparam logic [4:0] S_EDGE_WR   = 5'd2;
   localparam logic [4:0] S_READ_WAIT = 5'd3;
   localparam logic [4:0] S_DONE      = 5'd4;
   localparam logic [4:0] S_R_BASE    = 5'd5;
   localparam logic [4:0] S_R_QINIT   = 5'd6;
   localparam logic [4:0] S_R_INIT_WR = 5'd7;
   localparam logic [4:0] S_I_START   = 5'd8;
   localparam logic [4:0] S_M_RD      = 5'd9;
   localparam logic [4:0] S_M_ACC     = 5'd10;
   localparam logic [4:0] S_SH_MUL    = 5'd11;
   localparam logic [4:0] S_SH_DIV    = 5'd12;
   localparam logic [4:0] S_E_RD      = 5'd13;
   localparam logic [4:0] S_E_CHK     = 5'd14;
   localparam logic [4:0] S_E_DIV     = 5'd15;
   localparam logic [4:0] S_E_ACC     = 5'd16;
   localparam logic [4:0] S_U_RD      = 5'd17;
   localparam logic [4:0] S_U_MUL     = 5'd18;
   localparam logic [4:0] S_U_WR      = 5'd19;
   localparam logic [4:0] S_I_END     = 5'd20;

   // Configuration registers
   logic [VCOUNT_W-1:0] vcount_ff;
   logic [DAMP_W-1:0]   damp_ff;
   logic [RES_W-1:0]    tol_ff;
   logic [ITER_W-1:0]   limit_ff;

   // Sequencer registers
   logic [4:0]          state_ff, state_in;
   logic                launch_ff, launch_in;
   logic                sweep_all_ff, sweep_all_in;
   logic [NW-1:0]       v_ff, v_in;
   logic [ECW-1:0]      e_ff, e_in;
   logic [ECW-1:0]      edges_ff, edges_in;
   logic [ITER_W-1:0]   it_ff, it_in;
   logic [MASSW-1:0]    mass_ff, mass_in;
   logic [RANK_W-1:0]   base_ff, base_in;
   logic [DVDW-1:0]     share_ff, share_in;
   logic [RES_W-1:0]    resid_ff, resid_in;
   logic [ITER_W-1:0]   last_iter_ff, last_iter_in;
   logic                last_conv_ff, last_conv_in;
   logic [RES_W-1:0]    last_resid_ff, last_resid_in;
   logic [VW-1:0]       src_ff, src_in;
   logic [VW-1:0]       tgt_ff, tgt_in;
   logic [STATUS_W-1:0] status_ff, status_in;
   logic [RANK_W-1:0]   rank_res_ff, rank_res_in;
   logic                rsp_valid_ff, rsp_valid_in;
   rsp_type             rsp_item_ff, rsp_item_in;

   // Memories
   logic [EDW-1:0]    edge_mem [MAX_EDGES];
   logic [DGW-1:0]    deg_mem [MAX_VERTICES];
   logic [RANK_W-1:0] rank_mem [MAX_VERTICES];
   logic [SUMW-1:0]   sum_mem [MAX_VERTICES];
   logic [EDW-1:0]    edge_rd_ff;
   logic [DGW-1:0]    deg_rd_ff;
   logic [RANK_W-1:0] rank_rd_ff;
   logic [SUMW-1:0]   sum_rd_ff;

   // Memory port controls
   logic              edge_we, edge_re;
   logic [EDW-1:0]    edge_wd;
   logic              deg_we, deg_re;
   logic [VW-1:0]     deg_wa, deg_ra;
   logic [DGW-1:0]    deg_wd;
   logic              rank_we, rank_re;
   logic [VW-1:0]     rank_wa, rank_ra;
   logic [RANK_W-1:0] rank_wd;
   logic              sum_we, sum_re;
   logic [VW-1:0]     sum_wa, sum_ra;
   logic [SUMW-1:0]   sum_wd;

   // Shared units
   logic              div_start, div_busy, div_done;
   logic [DVDW-1:0]   div_dividend, div_quo;
   logic [DVSW-1:0]   div_divisor;
   logic              mul_start, mul_done;
   logic [MULW-1:0]   mul_x, mul_prod;

   // Datapath helpers
   logic              req_accept;
   logic [NW-1:0]     n_eff;
   logic              src_big, dst_big, query_big;
   logic              s_ok, t_ok;
   logic [VTX_W-1:0]  e_src, e_tgt;
   logic              last_vertex, last_edge;
   logic [NXW-1:0]    nx_sum;
   logic [RANK_W-1:0] nx;
   logic [RANK_W-1:0] nx_diff;
   logic [RES_W:0]    resid_sum;

   prpi_divider #(
      .DVDW(DVDW),
      .DVSW(DVSW)
   ) u_divider (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (div_dividend),
      .divisor  (div_divisor),
      .busy     (div_busy),
      .done     (div_done),
      .quotient (div_quo)
   );

   prpi_multiplier #(
      .XW(MULW)
   ) u_multiplier (
      .clock   (clock),
      .reset   (reset),
      .start   (mul_start),
      .x       (mul_x),
      .d       (damp_ff),
      .done    (mul_done),
      .product (mul_prod)
   );

   // Effective vertex count: zero acts as one, clamp at the memory depth
   always_comb begin
      if (vcount_ff == '0) begin
         n_eff = NW'(1);
      end else if (CMPW'(vcount_ff) > CMPW'(MAX_VERTICES)) begin
         n_eff = NW'(MAX_VERTICES);
      end else begin
         n_eff = NW'(vcount_ff);
      end
   end

   assign req_stall  = state_ff != S_IDLE;
   assign req_accept = req_valid && !req_stall;

   assign src_big   = CMPW'(req_item.edge_source) >= CMPW'(n_eff);
   assign dst_big   = CMPW'(req_item.edge_target) >= CMPW'(n_eff);
   assign query_big = CMPW'(req_item.query_vertex) >= CMPW'(n_eff);

   assign e_src = edge_rd_ff[EDW-1:VTX_W];
   assign e_tgt = edge_rd_ff[VTX_W-1:0];
   assign s_ok  = CMPW'(e_src) < CMPW'(n_eff);
   assign t_ok  = CMPW'(e_tgt) < CMPW'(n_eff);

   assign last_vertex = (v_ff + NW'(1)) == n_eff;
   assign last_edge   = (e_ff + ECW'(1)) == edges_ff;

   // Next rank and residual of the update pass
   assign nx_sum    = NXW'(base_ff) + NXW'(share_ff) + NXW'(mul_prod);
   assign nx        = (nx_sum > NXW'(RANK_MAX)) ? RANK_MAX : nx_sum[RANK_W-1:0];
   assign nx_diff   = (nx >= rank_rd_ff) ? nx - rank_rd_ff : rank_rd_ff - nx;
   assign resid_sum = {1'b0, resid_ff} + (RES_W + 1)'(nx_diff);

   // Shared unit operands
   always_comb begin
      div_dividend = DVDW'(rank_rd_ff);
      div_divisor  = DVSW'(n_eff);
      mul_x        = MULW'(sum_rd_ff);
      unique case (state_ff)
         S_R_BASE: begin
            div_dividend = DVDW'({(17'h1_0000 - {1'b0, damp_ff}), 15'd0});
         end
         S_R_QINIT: begin
            div_dividend = DVDW'(33'h0_8000_0000);
         end
         S_SH_DIV: begin
            div_dividend = DVDW'(mul_prod);
         end
         S_E_DIV: begin
            div_divisor = DVSW'(deg_rd_ff);
         end
         S_SH_MUL: begin
            mul_x = MULW'(mass_ff);
         end
         default: begin
         end
      endcase
   end

   // Launch each unit once per waiting state
   assign div_start = !launch_ff &&
      ((state_ff == S_R_BASE) || (state_ff == S_R_QINIT) || (state_ff == S_SH_DIV) ||
       ((state_ff == S_E_DIV) && (deg_rd_ff != '0)));
   assign mul_start = !launch_ff && ((state_ff == S_SH_MUL) || (state_ff == S_U_MUL));
   assign launch_in = (state_in != state_ff) ? 1'b0 : (launch_ff || div_start || mul_start);

   // Sequencer
   always_comb begin
      state_in      = state_ff;
      sweep_all_in  = sweep_all_ff;
      v_in          = v_ff;
      e_in          = e_ff;
      edges_in      = edges_ff;
      it_in         = it_ff;
      mass_in       = mass_ff;
      base_in       = base_ff;
      share_in      = share_ff;
      resid_in      = resid_ff;
      last_iter_in  = last_iter_ff;
      last_conv_in  = last_conv_ff;
      last_resid_in = last_resid_ff;
      src_in        = src_ff;
      tgt_in        = tgt_ff;
      status_in     = status_ff;
      rank_res_in   = rank_res_ff;
      rsp_valid_in  = rsp_valid_ff && rsp_stall;
      rsp_item_in   = rsp_item_ff;

      edge_we = 1'b0;
      edge_re = 1'b0;
      edge_wd = {req_item.edge_source, req_item.edge_target};
      deg_we  = 1'b0;
      deg_re  = 1'b0;
      deg_wa  = v_ff[VW-1:0];
      deg_ra  = v_ff[VW-1:0];
      deg_wd  = '0;
      rank_we = 1'b0;
      rank_re = 1'b0;
      rank_wa = v_ff[VW-1:0];
      rank_ra = v_ff[VW-1:0];
      rank_wd = '0;
      sum_we  = 1'b0;
      sum_re  = 1'b0;
      sum_wa  = v_ff[VW-1:0];
      sum_ra  = v_ff[VW-1:0];
      sum_wd  = '0;

      unique case (state_ff)
         // Zero degrees, and ranks too after reset
         S_SWEEP: begin
            deg_we  = 1'b1;
            rank_we = sweep_all_ff;
            v_in    = v_ff + NW'(1);
            if (v_ff == NW'(MAX_VERTICES - 1)) begin
               v_in     = '0;
               state_in = sweep_all_ff ? S_IDLE : S_DONE;
            end
         end

         // Take an item
         S_IDLE: begin
            if (req_accept) begin
               status_in   = STATUS_OK;
               rank_res_in = '0;
               unique case (req_item.command)
                  CMD_ADD_EDGE: begin
                     if (src_big || dst_big) begin
                        status_in = STATUS_RANGE;
                        state_in  = S_DONE;
                     end else if (edges_ff == ECW'(MAX_EDGES)) begin
                        status_in = STATUS_FULL;
                        state_in  = S_DONE;
                     end else begin
                        edge_we  = 1'b1;
                        edges_in = edges_ff + ECW'(1);
                        deg_re   = 1'b1;
                        deg_ra   = VW'(req_item.edge_source);
                        src_in   = VW'(req_item.edge_source);
                        state_in = S_EDGE_WR;
                     end
                  end
                  CMD_RUN: begin
                     state_in = S_R_BASE;
                  end
                  CMD_READ: begin
                     if (query_big) begin
                        status_in = STATUS_RANGE;
                        state_in  = S_DONE;
                     end else begin
                        rank_re  = 1'b1;
                        rank_ra  = VW'(req_item.query_vertex);
                        state_in = S_READ_WAIT;
                     end
                  end
                  CMD_CLEAR: begin
                     edges_in     = '0;
                     v_in         = '0;
                     sweep_all_in = 1'b0;
                     state_in     = S_SWEEP;
                  end
                  default: begin
                  end
               endcase
            end
         end

         // Count the new edge on its source
         S_EDGE_WR: begin
            deg_we   = 1'b1;
            deg_wa   = src_ff;
            deg_wd   = deg_rd_ff + DGW'(1);
            state_in = S_DONE;
         end

         S_READ_WAIT: begin
            rank_res_in = rank_rd_ff;
            state_in    = S_DONE;
         end

         // Hold the result until the output register is free
         S_DONE: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in = 1'b1;
               rsp_item_in  = '{status:          status_ff,
                                rank_value:      rank_res_ff,
                                iterations_done: last_iter_ff,
                                converged:       last_conv_ff,
                                residual:        last_resid_ff};
               state_in     = S_IDLE;
            end
         end

         // base = (1 - d) / n
         S_R_BASE: begin
            if (div_done) begin
               base_in  = div_quo[RANK_W-1:0];
               state_in = S_R_QINIT;
            end
         end

         // Starting rank 1 / n
         S_R_QINIT: begin
            if (div_done) begin
               v_in     = '0;
               state_in = S_R_INIT_WR;
            end
         end

         S_R_INIT_WR: begin
            rank_we = 1'b1;
            rank_wd = div_quo[RANK_W-1:0];
            v_in    = v_ff + NW'(1);
            if (last_vertex) begin
               it_in         = '0;
               last_iter_in  = '0;
               last_conv_in  = 1'b0;
               last_resid_in = '0;
               state_in      = (limit_ff == '0) ? S_DONE : S_I_START;
            end
         end

         S_I_START: begin
            v_in     = '0;
            mass_in  = '0;
            state_in = S_M_RD;
         end

         // Clear incoming sums, gather the dangling mass
         S_M_RD: begin
            deg_re   = 1'b1;
            rank_re  = 1'b1;
            sum_we   = 1'b1;
            state_in = S_M_ACC;
         end

         S_M_ACC: begin
            if (deg_rd_ff == '0) begin
               mass_in = mass_ff + MASSW'(rank_rd_ff);
            end
            v_in     = v_ff + NW'(1);
            state_in = last_vertex ? S_SH_MUL : S_M_RD;
         end

         S_SH_MUL: begin
            if (mul_done) begin
               state_in = S_SH_DIV;
            end
         end

         // share = d * mass / n
         S_SH_DIV: begin
            if (div_done) begin
               share_in = div_quo;
               e_in     = '0;
               v_in     = '0;
               resid_in = '0;
               state_in = (edges_ff == '0) ? S_U_RD : S_E_RD;
            end
         end

         S_E_RD: begin
            edge_re  = 1'b1;
            state_in = S_E_CHK;
         end

         // Drop edges with an end at or beyond n
         S_E_CHK: begin
            if (s_ok && t_ok) begin
               deg_re   = 1'b1;
               deg_ra   = VW'(e_src);
               rank_re  = 1'b1;
               rank_ra  = VW'(e_src);
               src_in   = VW'(e_src);
               tgt_in   = VW'(e_tgt);
               state_in = S_E_DIV;
            end else begin
               e_in = e_ff + ECW'(1);
               if (last_edge) begin
                  state_in = S_U_RD;
               end else begin
                  state_in = S_E_RD;
               end
            end
         end

         // rank[s] / deg[s]
         S_E_DIV: begin
            if (deg_rd_ff == '0) begin
               e_in     = e_ff + ECW'(1);
               state_in = last_edge ? S_U_RD : S_E_RD;
            end else if (div_done) begin
               sum_re   = 1'b1;
               sum_ra   = tgt_ff;
               state_in = S_E_ACC;
            end
         end

         S_E_ACC: begin
            sum_we   = 1'b1;
            sum_wa   = tgt_ff;
            sum_wd   = sum_rd_ff + SUMW'(div_quo[RANK_W-1:0]);
            e_in     = e_ff + ECW'(1);
            state_in = last_edge ? S_U_RD : S_E_RD;
         end

         S_U_RD: begin
            sum_re   = 1'b1;
            rank_re  = 1'b1;
            state_in = S_U_MUL;
         end

         S_U_MUL: begin
            if (mul_done) begin
               state_in = S_U_WR;
            end
         end

         // Write the new rank in place and add to the residual
         S_U_WR: begin
            rank_we  = 1'b1;
            rank_wd  = nx;
            resid_in = (resid_sum > (RES_W + 1)'(RESIDUAL_MAX)) ?
                       RESIDUAL_MAX : resid_sum[RES_W-1:0];
            v_in     = v_ff + NW'(1);
            state_in = last_vertex ? S_I_END : S_U_RD;
         end

         // Close the iteration
         S_I_END: begin
            it_in         = it_ff + ITER_W'(1);
            last_iter_in  = it_ff + ITER_W'(1);
            last_resid_in = resid_ff;
            if (resid_ff <= tol_ff) begin
               last_conv_in = 1'b1;
               state_in     = S_DONE;
            end else if ((it_ff + ITER_W'(1)) == limit_ff) begin
               state_in = S_DONE;
            end else begin
               state_in = S_I_START;
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_SWEEP;
         launch_ff     <= 1'b0;
         sweep_all_ff  <= 1'b1;
         v_ff          <= '0;
         e_ff          <= '0;
         edges_ff      <= '0;
         it_ff         <= '0;
         last_iter_ff  <= '0;
         last_conv_ff  <= 1'b0;
         last_resid_ff <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         launch_ff     <= launch_in;
         sweep_all_ff  <= sweep_all_in;
         v_ff          <= v_in;
         e_ff          <= e_in;
         edges_ff      <= edges_in;
         it_ff         <= it_in;
         last_iter_ff  <= last_iter_in;
         last_conv_ff  <= last_conv_in;
         last_resid_ff <= last_resid_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      mass_ff     <= mass_in;
      base_ff     <= base_in;
      share_ff    <= share_in;
      resid_ff    <= resid_in;
      src_ff      <= src_in;
      tgt_ff      <= tgt_in;
      status_ff   <= status_in;
      rank_res_ff <= rank_res_in;
      rsp_item_ff <= rsp_item_in;
   end

   // Configuration writes
   always_ff @(posedge clock) begin
      if (reset) begin
         vcount_ff <= RST_VERTEX_COUNT;
         damp_ff   <= RST_DAMPING;
         tol_ff    <= RST_TOLERANCE;
         limit_ff  <= RST_ITERATION_LIMIT;
      end else if (csr_write) begin
         unique case (csr_index)
            REG_VERTEX_COUNT:    vcount_ff <= csr_data[VCOUNT_W-1:0];
            REG_DAMPING:         damp_ff   <= csr_data[DAMP_W-1:0];
            REG_TOLERANCE:       tol_ff    <= csr_data[RES_W-1:0];
            REG_ITERATION_LIMIT: limit_ff  <= csr_data[ITER_W-1:0];
            default: begin
            end
         endcase
      end
   end

   // Edge store
   always_ff @(posedge clock) begin
      if (edge_we) begin
         edge_mem[edges_ff[EAW-1:0]] <= edge_wd;
      end
      if (edge_re) begin
         edge_rd_ff <= edge_mem[e_ff[EAW-1:0]];
      end
   end

   // Out-degree memory
   always_ff @(posedge clock) begin
      if (deg_we) begin
         deg_mem[deg_wa] <= deg_wd;
      end
      if (deg_re) begin
         deg_rd_ff <= deg_mem[deg_ra];
      end
   end

   // Rank memory
   always_ff @(posedge clock) begin
      if (rank_we) begin
         rank_mem[rank_wa] <= rank_wd;
      end
      if (rank_re) begin
         rank_rd_ff <= rank_mem[rank_ra];
      end
   end

   // Incoming sum memory
   always_ff @(posedge clock) begin
      if (sum_we) begin
         sum_mem[sum_wa] <= sum_wd;
      end
      if (sum_re) begin
         sum_rd_ff <= sum_mem[sum_ra];
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_item  = rsp_item_ff;

   // Checks
   a_edges_bound: assert property (@(posedge clock) disable iff (reset)
      edges_ff <= ECW'(MAX_EDGES))
      else $error("edge count beyond store depth");

   a_rsp_from_done: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff) == S_DONE)
      else $error("result loaded outside the done state");

   a_conv_iter: assert property (@(posedge clock) disable iff (reset)
      last_conv_ff |-> last_iter_ff != '0)
      else $error("converged with no iteration");

   a_div_idle: assert property (@(posedge clock) disable iff (reset)
      div_start |-> !div_busy)
      else $error("divider restarted while busy");

endmodule

// ===== tb/pagerank_checker.sv =====
// Checker for the PageRank core: snoops the channels and registers, predicts and compares.
module pagerank_checker import prpi_pkg::*; (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   input  logic                   req_stall,
   input  req_type                req_item,
   input  logic                   rsp_valid,
   input  logic                   rsp_stall,
   input  rsp_type                rsp_item,
   input  logic                   csr_write,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_data,
   output int                     failures,
   output int                     pending
);

   localparam int NV = DEF_MAX_VERTICES;
   localparam int NE = DEF_MAX_EDGES;
   localparam longint unsigned RES_SAT  = 64'h3_FFFF_FFFF;
   localparam longint unsigned RANK_SAT = 64'hFFFF_FFFF;

   // Mirrored registers
   logic [VCOUNT_W-1:0] vcount;
   int unsigned         damp;
   longint unsigned     tol;
   int unsigned         iter_max;

   // Mirrored graph and rank state
   int unsigned     src_store [NE];
   int unsigned     dst_store [NE];
   int unsigned     edge_total;
   int unsigned     degree [NV];
   int unsigned     rank_now [NV];
   int unsigned     rank_new [NV];
   longint unsigned incoming [NV];
   int unsigned     run_iters;
   bit              run_conv;
   longint unsigned run_res;

   rsp_type expected_rsp[$];

   function automatic int unsigned vertices_in_use();
      if (vcount == 0) return 1;
      if (vcount > NV) return NV;
      return vcount;
   endfunction

   // floor(x * d / 2^16) with no overflow
   function automatic longint unsigned damp_scale(longint unsigned x);
      longint unsigned d;
      d = damp;
      return (x >> 16) * d + (((x & 64'hFFFF) * d) >> 16);
   endfunction

   // One full run: reset ranks to 1/n, then iterate to tolerance or limit
   function automatic void power_iterate();
      int unsigned     n, v, e, it, s, t;
      longint unsigned base, mass, share, res, nx, cur;
      bit              done;
      n = vertices_in_use();
      base = (longint'(65536 - damp) << 15) / n;
      for (v = 0; v < n; v++) rank_now[v] = 32'(((64'd1) << 31) / n);
      run_iters = 0;
      run_conv = 0;
      run_res = 0;
      done = 0;
      for (it = 0; it < iter_max && !done; it++) begin
         mass = 0;
         for (v = 0; v < n; v++) begin
            incoming[v] = 0;
            if (degree[v] == 0) mass += rank_now[v];
         end
         share = damp_scale(mass) / n;
         for (e = 0; e < edge_total; e++) begin
            s = src_store[e];
            t = dst_store[e];
            if (s < n && t < n && degree[s] != 0)
               incoming[t] += longint'(rank_now[s]) / degree[s];
         end
         res = 0;
         for (v = 0; v < n; v++) begin
            nx = base + share + damp_scale(incoming[v]);
            cur = rank_now[v];
            if (nx > RANK_SAT) nx = RANK_SAT;
            rank_new[v] = 32'(nx);
            res += (nx >= cur) ? nx - cur : cur - nx;
         end
         if (res > RES_SAT) res = RES_SAT;
         for (v = 0; v < n; v++) rank_now[v] = rank_new[v];
         run_iters = it + 1;
         run_res = res;
         if (res <= tol) begin
            run_conv = 1;
            done = 1;
         end
      end
   endfunction

   // Apply one item to the mirrored state and form its result
   function automatic rsp_type predict_rsp(req_type r);
      rsp_type     p;
      int unsigned n;
      n = vertices_in_use();
      p = '0;
      p.status = STATUS_OK;
      case (r.command)
         CMD_ADD_EDGE: begin
            if (r.edge_source >= n || r.edge_target >= n) begin
               p.status = STATUS_RANGE;
            end else if (edge_total >= NE) begin
               p.status = STATUS_FULL;
            end else begin
               src_store[edge_total] = r.edge_source;
               dst_store[edge_total] = r.edge_target;
               edge_total++;
               degree[r.edge_source]++;
            end
         end
         CMD_RUN: power_iterate();
         CMD_READ: begin
            if (r.query_vertex >= n) p.status = STATUS_RANGE;
            else p.rank_value = rank_now[r.query_vertex];
         end
         default: begin
            edge_total = 0;
            foreach (degree[i]) degree[i] = 0;
         end
      endcase
      p.iterations_done = ITER_W'(run_iters);
      p.converged = run_conv;
      p.residual = RES_W'(run_res);
      return p;
   endfunction

   always @(posedge clock) begin
      rsp_type want;
      int      errs;
      if (reset) begin
         vcount <= RST_VERTEX_COUNT;
         damp <= RST_DAMPING;
         tol <= RST_TOLERANCE;
         iter_max <= RST_ITERATION_LIMIT;
         edge_total = 0;
         foreach (degree[i]) degree[i] = 0;
         foreach (rank_now[i]) rank_now[i] = 0;
         run_iters = 0;
         run_conv = 0;
         run_res = 0;
         expected_rsp.delete();
         failures <= 0;
      end else begin
         // Track register writes
         if (csr_write) begin
            case (csr_index)
               REG_VERTEX_COUNT:    vcount <= csr_data[VCOUNT_W-1:0];
               REG_DAMPING:         damp <= csr_data[DAMP_W-1:0];
               REG_TOLERANCE:       tol <= csr_data[RES_W-1:0];
               REG_ITERATION_LIMIT: iter_max <= csr_data[ITER_W-1:0];
               default: ;
            endcase
         end
         // Compare each result item with the oldest prediction
         if (rsp_valid && !rsp_stall) begin
            if (expected_rsp.size() == 0) begin
               $error("result item with no prediction waiting");
               failures <= failures + 1;
            end else begin
               errs = 0;
               want = expected_rsp.pop_front();
               if (rsp_item.status !== want.status) begin
                  $error("status: expected %0d, got %0d", want.status, rsp_item.status);
                  errs++;
               end
               if (rsp_item.rank_value !== want.rank_value) begin
                  $error("rank_value: expected %0d, got %0d",
                         want.rank_value, rsp_item.rank_value);
                  errs++;
               end
               if (rsp_item.iterations_done !== want.iterations_done) begin
                  $error("iterations_done: expected %0d, got %0d",
                         want.iterations_done, rsp_item.iterations_done);
                  errs++;
               end
               if (rsp_item.converged !== want.converged) begin
                  $error("converged: expected %0d, got %0d",
                         want.converged, rsp_item.converged);
                  errs++;
               end
               if (rsp_item.residual !== want.residual) begin
                  $error("residual: expected %0d, got %0d",
                         want.residual, rsp_item.residual);
                  errs++;
               end
               failures <= failures + errs;
            end
         end
         // Predict each accepted item
         if (req_valid && !req_stall) expected_rsp = {expected_rsp, predict_rsp(req_item)};
      end
      pending <= expected_rsp.size();
   end

endmodule

// ===== tb/testbench.sv =====
// Top of the PageRank core test: stimulus, register phases, watchdog and verdict.
module testbench;
   import prpi_pkg::*;

   localparam int QUIET_LIMIT = 400000;

   logic                   clock = 0;
   logic                   reset = 1;
   logic                   req_valid = 0;
   logic                   req_stall;
   req_type                req_item = '0;
   logic                   rsp_valid;
   logic                   rsp_stall = 0;
   rsp_type                rsp_item;
   logic                   csr_write = 0;
   logic [CSR_INDEX_W-1:0] csr_index = REG_VERTEX_COUNT;
   logic [CSR_DATA_W-1:0]  csr_data = '0;
   int                     failures;
   int                     pending;
   int                     idle_pct = 0;
   int                     stall_pct = 0;
   int                     quiet = 0;

   pagerank_power_iteration_core i_dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_item(req_item),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_item(rsp_item),
      .csr_write(csr_write), .csr_index(csr_index), .csr_data(csr_data)
   );

   pagerank_checker i_checker (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_item(req_item),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_item(rsp_item),
      .csr_write(csr_write), .csr_index(csr_index), .csr_data(csr_data),
      .failures(failures), .pending(pending)
   );

   always begin
      #6 clock = 1;
      #6 clock = 0;
   end

   // Stall the result channel at the phase's rate
   always @(posedge clock) rsp_stall <= ($urandom_range(99) < stall_pct);

   // End the run when nothing moves for too long
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) quiet <= 0;
      else quiet <= quiet + 1;
      if (quiet >= QUIET_LIMIT) begin
         $display("SCOREBOARD MISMATCH");
         $finish;
      end
   end

   // Send one item, after a random idle gap
   task automatic send(logic [CMD_W-1:0] cmd, int s, int t, int q);
      while ($urandom_range(99) < idle_pct) begin
         req_valid <= 0;
         @(posedge clock);
      end
      req_valid <= 1;
      req_item.command <= cmd;
      req_item.edge_source <= VTX_W'(s);
      req_item.edge_target <= VTX_W'(t);
      req_item.query_vertex <= VTX_W'(q);
      do @(posedge clock); while (req_stall);
   endtask

   // Drop valid and wait until every predicted result is back
   task automatic drain();
      req_valid <= 0;
      @(posedge clock);
      wait (pending == 0);
      repeat (8) @(posedge clock);
   endtask

   // Write all four registers while idle
   task automatic configure(int vc, int d, longint tl, int lim);
      csr_write <= 1;
      csr_index <= REG_VERTEX_COUNT; csr_data <= CSR_DATA_W'(vc);
      @(posedge clock);
      csr_index <= REG_DAMPING; csr_data <= CSR_DATA_W'(d);
      @(posedge clock);
      csr_index <= REG_TOLERANCE; csr_data <= CSR_DATA_W'(tl);
      @(posedge clock);
      csr_index <= REG_ITERATION_LIMIT; csr_data <= CSR_DATA_W'(lim);
      @(posedge clock);
      csr_write <= 0;
      @(posedge clock);
   endtask

   task automatic set_pressure(int phase);
      case (phase % 4)
         0: begin idle_pct = 0;  stall_pct = 0;  end
         1: begin idle_pct = 88; stall_pct = 0;  end
         2: begin idle_pct = 0;  stall_pct = 88; end
         default: begin idle_pct = 29; stall_pct = 29; end
      endcase
   endtask

   // Random vertex: mostly in range, sometimes any 10-bit value
   function automatic int pick_vertex(int n);
      if ($urandom_range(9) == 0) return $urandom_range(1023);
      return $urandom_range(n - 1);
   endfunction

   initial begin
      int  n, roll;
      repeat (12) @(posedge clock);
      reset <= 0;
      @(posedge clock);

      // Directed: reads before any run, then a single-vertex run
      set_pressure(0);
      send(CMD_READ, 0, 0, 0);
      send(CMD_READ, 0, 0, 1023);
      send(CMD_RUN, 0, 0, 0);
      send(CMD_READ, 0, 0, 0);
      drain();

      // Small cycle with self loop, duplicate and out-of-range edges
      configure(4, 65535, 1, 3);
      send(CMD_ADD_EDGE, 0, 1, 0);
      send(CMD_ADD_EDGE, 1, 2, 0);
      send(CMD_ADD_EDGE, 2, 0, 0);
      send(CMD_ADD_EDGE, 0, 0, 0);
      send(CMD_ADD_EDGE, 0, 1, 0);
      send(CMD_ADD_EDGE, 3, 3, 0);
      send(CMD_ADD_EDGE, 4, 0, 0);
      send(CMD_ADD_EDGE, 0, 1023, 0);
      send(CMD_RUN, 0, 0, 0);
      send(CMD_READ, 0, 0, 2);
      send(CMD_READ, 0, 0, 4);
      drain();

      // Shrink n with stale edges, zero damping, zero then small limits
      configure(2, 0, 64'h3_FFFF_FFFF, 0);
      send(CMD_RUN, 0, 0, 0);
      send(CMD_READ, 0, 0, 0);
      drain();
      configure(2, 32768, 1, 5);
      send(CMD_RUN, 0, 0, 0);
      send(CMD_READ, 0, 0, 1);
      send(CMD_READ, 0, 0, 3);
      send(CMD_CLEAR, 0, 0, 0);
      send(CMD_READ, 0, 0, 1);
      send(CMD_RUN, 0, 0, 0);
      drain();

      // Oversized and zero vertex counts
      configure(2047, 55706, 64'h3_FFFF_FFFF, 1);
      send(CMD_ADD_EDGE, 1023, 0, 0);
      send(CMD_ADD_EDGE, 0, 1023, 0);
      send(CMD_RUN, 0, 0, 0);
      send(CMD_READ, 0, 0, 1023);
      drain();
      configure(0, 100, 2147, 65535);
      send(CMD_ADD_EDGE, 1, 0, 0);
      send(CMD_RUN, 0, 0, 0);
      send(CMD_READ, 0, 0, 0);
      drain();

      // Start the random phases from an empty graph
      configure(4, 55706, 2147, 4);
      send(CMD_CLEAR, 0, 0, 0);
      drain();

      // Random phases: small graphs, mostly well-formed edges and reads
      for (int ph = 0; ph < 8; ph++) begin
         n = $urandom_range(1, 8);
         configure(n, $urandom_range(65535),
                   ($urandom_range(1) != 0) ? longint'($urandom_range(1, 50000))
                                            : {$urandom_range(3), $urandom},
                   $urandom_range(0, 10));
         set_pressure(ph);
         send(CMD_CLEAR, 0, 0, 0);
         for (int i = 0; i < 190; i++) begin
            roll = $urandom_range(99);
            if (roll < 55)
               send(CMD_ADD_EDGE, pick_vertex(n), pick_vertex(n), $urandom_range(1023));
            else if (roll < 88)
               send(CMD_READ, $urandom_range(1023), $urandom_range(1023), pick_vertex(n));
            else if (roll < 92)
               send(CMD_RUN, $urandom_range(1023), $urandom_range(1023), $urandom_range(1023));
            else
               send(CMD_CLEAR, $urandom_range(1023), $urandom_range(1023), 0);
         end
         drain();
      end

      if (failures == 0) $display("SCOREBOARD CLEAN");
      else $display("SCOREBOARD MISMATCH");
      $finish;
   end

endmodule
